// ===== hdl/tlc_pkg.sv =====
`default_nettype none

package tlc_pkg;

   localparam int PENDING_SPACE_DEPTH = 32;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_XFF   = 8'hFF;
   localparam logic [7:0] U8_E2    = 8'hE2;
   localparam logic [7:0] U8_80    = 8'h80;
   localparam logic [7:0] U8_A8    = 8'hA8;
   localparam logic [7:0] U8_A9    = 8'hA9;
   localparam logic [7:0] U8_C2    = 8'hC2;
   localparam logic [7:0] U8_85    = 8'h85;
   localparam logic [7:0] U8_A0    = 8'hA0;
   localparam logic [7:0] BOM_0    = 8'hEF;
   localparam logic [7:0] BOM_1    = 8'hBB;
   localparam logic [7:0] BOM_2    = 8'hBF;

   localparam logic [15:0] LINE_COUNT_MAX = 16'hFFFF;
   localparam logic [1:0]  BOM_DONE       = 2'd3;
   localparam logic [1:0]  BOM_LAST_POS   = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        line_end;
      logic        stream_end;
      logic [15:0] line_count;
      logic        ws_dropped;
      logic        run_last;
   } rsp_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECIDE = 7'b0000010,
      ST_WR2    = 7'b0000100,
      ST_FL_RD  = 7'b0001000,
      ST_FL_WR  = 7'b0010000,
      ST_TEXT   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/tlc_ram.sv =====
`default_nettype none

module tlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/text_line_cleaner_unit.sv =====
// text_line_cleaner_unit: cleans a text file streamed in one byte per transfer.
// Input channel req_*: one raw file byte per transfer, in_last set on the final byte.
// Output channel rsp_*: cleaned line bytes, a zero terminator item after each kept
// line, and after the final byte one end item that carries the kept-line count.
// A leading byte order mark, comments, blank lines and outer whitespace are removed;
// interior whitespace is held in a small RAM and released before the next text byte.
// Steps: a byte is taken in the idle state and decided in the decide state, and a
// text byte is then output in the text state. Up to two bytes wait as lookahead
// before a decision is made, so a byte that only fills the lookahead is just taken.
// Each held whitespace byte released is read from the RAM and then output; a
// two-byte whitespace sequence passes through an extra RAM write state. The final
// byte decides every waiting byte plus the implied newline (up to 4 decisions) and
// then gives the end item. run_last marks the last result item caused by a transfer.
// Reset is synchronous; it empties the lookahead and clears all line state. After
// the end item the unit returns to that state by itself and the next byte starts a
// new file. A stall on rsp_ready holds the result register and the unit waits;
// req_ready is high only in the idle state.
`default_nettype none

module text_line_cleaner_unit #(
   parameter int PENDING_SPACE_DEPTH = tlc_pkg::PENDING_SPACE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tlc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tlc_pkg::rsp_type      rsp_data
);

   localparam int AW = (PENDING_SPACE_DEPTH > 1) ? $clog2(PENDING_SPACE_DEPTH) : 1;
   localparam int CW = $clog2(PENDING_SPACE_DEPTH + 1);

   tlc_pkg::state_type state_ff, state_in;
   logic [1:0]         bom_ff, bom_in;
   logic [3:0][7:0]    win_ff, win_in;
   logic [2:0]         wn_ff, wn_in;
   logic               last_ff, last_in;
   logic               in_text_ff, in_text_in;
   logic               comment_ff, comment_in;
   logic               has_text_ff, has_text_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [15:0]        kept_ff, kept_in;
   logic               pend_ovf_ff, pend_ovf_in;
   logic               line_ovf_ff, line_ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   tlc_pkg::rsp_type   rsp_ff, rsp_in;

   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [7:0]         ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [7:0]         ram_rd_data;

   logic               accept;
   logic               can_emit;
   logic [1:0]         nl_k;
   logic [1:0]         sp_k;
   logic               is_slash2;
   logic [CW:0]        fill_sum;
   logic [15:0]        kept_sat;
   logic               emit;
   tlc_pkg::rsp_type   item;
   logic               adv;
   logic [1:0]         adv_k;
   logic [2:0]         wn_left;
   logic [3:0][7:0]    win_acc;
   logic [2:0]         wn_acc;

   tlc_ram #(
      .WIDTH (8),
      .DEPTH (PENDING_SPACE_DEPTH)
   ) u_space_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == tlc_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // newline and whitespace recognition at the head of the window
   always_comb begin
      nl_k = 2'd0;
      if (wn_ff >= 3'd3 && win_ff[0] == tlc_pkg::U8_E2 && win_ff[1] == tlc_pkg::U8_80 &&
          (win_ff[2] == tlc_pkg::U8_A8 || win_ff[2] == tlc_pkg::U8_A9)) begin
         nl_k = 2'd3;
      end else if (wn_ff >= 3'd2 &&
                   ((win_ff[0] == tlc_pkg::CH_CR && win_ff[1] == tlc_pkg::CH_LF) ||
                    (win_ff[0] == tlc_pkg::U8_C2 && win_ff[1] == tlc_pkg::U8_85))) begin
         nl_k = 2'd2;
      end else if (wn_ff >= 3'd1 &&
                   (win_ff[0] == tlc_pkg::CH_LF || win_ff[0] == tlc_pkg::CH_VT ||
                    win_ff[0] == tlc_pkg::CH_FF || win_ff[0] == tlc_pkg::CH_CR)) begin
         nl_k = 2'd1;
      end
      sp_k = 2'd0;
      if (wn_ff >= 3'd2 && win_ff[0] == tlc_pkg::U8_C2 && win_ff[1] == tlc_pkg::U8_A0) begin
         sp_k = 2'd2;
      end else if (win_ff[0] == tlc_pkg::CH_TAB || win_ff[0] == tlc_pkg::CH_SPACE ||
                   win_ff[0] == tlc_pkg::CH_XFF) begin
         sp_k = 2'd1;
      end
      is_slash2 = (win_ff[0] == tlc_pkg::CH_SLASH) && (wn_ff >= 3'd2) &&
                  (win_ff[1] == tlc_pkg::CH_SLASH);
   end

   assign fill_sum = {1'b0, count_ff} + (CW+1)'(sp_k);
   assign kept_sat = (kept_ff == tlc_pkg::LINE_COUNT_MAX) ? kept_ff : kept_ff + 16'd1;

   // window after taking a new byte (and the implied newline on the final byte)
   always_comb begin
      win_acc = win_ff;
      for (int i = 0; i < 4; i++) begin
         if (3'(i) == wn_ff) begin
            win_acc[i] = req_data.in_byte;
         end
         if (req_data.in_last && 3'(i) == wn_ff + 3'd1) begin
            win_acc[i] = tlc_pkg::CH_LF;
         end
      end
      wn_acc = wn_ff + 3'd1 + {2'b00, req_data.in_last};
      // order mark on the first three bytes
      if (bom_ff == tlc_pkg::BOM_LAST_POS && wn_ff == 3'd2 &&
          win_ff[0] == tlc_pkg::BOM_0 && win_ff[1] == tlc_pkg::BOM_1 &&
          req_data.in_byte == tlc_pkg::BOM_2) begin
         win_acc[0] = tlc_pkg::CH_LF;
         wn_acc     = {2'b00, req_data.in_last};
      end
   end

   always_comb begin
      state_in    = state_ff;
      bom_in      = bom_ff;
      win_in      = win_ff;
      wn_in       = wn_ff;
      last_in     = last_ff;
      in_text_in  = in_text_ff;
      comment_in  = comment_ff;
      has_text_in = has_text_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      kept_in     = kept_ff;
      pend_ovf_in = pend_ovf_ff;
      line_ovf_in = line_ovf_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[AW-1:0];
      ram_wr_data = win_ff[0];
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[AW-1:0];
      emit        = 1'b0;
      item        = '0;
      adv         = 1'b0;
      adv_k       = 2'd1;
      wn_left     = wn_ff;

      unique case (state_ff)
         tlc_pkg::ST_IDLE: begin
            if (accept) begin
               win_in  = win_acc;
               wn_in   = wn_acc;
               last_in = req_data.in_last;
               bom_in  = (bom_ff == tlc_pkg::BOM_DONE) ? bom_ff : bom_ff + 2'd1;
               if (req_data.in_last || wn_acc == 3'd3) begin
                  state_in = tlc_pkg::ST_DECIDE;
               end
            end
         end
         tlc_pkg::ST_DECIDE: begin
            if (nl_k != 2'd0) begin
               if (!has_text_ff || can_emit) begin
                  if (has_text_ff) begin
                     emit            = 1'b1;
                     item.line_end   = 1'b1;
                     item.line_count = kept_sat;
                     item.ws_dropped = line_ovf_ff;
                     item.run_last   = !last_ff;
                     kept_in         = kept_sat;
                  end
                  in_text_in  = 1'b0;
                  comment_in  = 1'b0;
                  has_text_in = 1'b0;
                  count_in    = '0;
                  pend_ovf_in = 1'b0;
                  line_ovf_in = 1'b0;
                  adv         = 1'b1;
                  adv_k       = nl_k;
               end
            end else if (sp_k != 2'd0) begin
               if (in_text_ff && !comment_ff) begin
                  if (fill_sum <= (CW+1)'(PENDING_SPACE_DEPTH)) begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + CW'(1);
                     if (sp_k == 2'd2) begin
                        state_in = tlc_pkg::ST_WR2;
                     end else begin
                        adv = 1'b1;
                     end
                  end else begin
                     pend_ovf_in = 1'b1;
                     adv         = 1'b1;
                     adv_k       = sp_k;
                  end
               end else begin
                  adv   = 1'b1;
                  adv_k = sp_k;
               end
            end else if (comment_ff) begin
               adv = 1'b1;
            end else if (is_slash2) begin
               comment_in  = 1'b1;
               in_text_in  = 1'b1;
               count_in    = '0;
               pend_ovf_in = 1'b0;
               adv         = 1'b1;
            end else begin
               line_ovf_in = line_ovf_ff || pend_ovf_ff;
               pend_ovf_in = 1'b0;
               idx_in      = '0;
               state_in    = (count_ff == '0) ? tlc_pkg::ST_TEXT : tlc_pkg::ST_FL_RD;
            end
         end
         tlc_pkg::ST_WR2: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = win_ff[1];
            count_in    = count_ff + CW'(1);
            adv         = 1'b1;
            adv_k       = 2'd2;
         end
         tlc_pkg::ST_FL_RD: begin
            ram_rd_en = 1'b1;
            state_in  = tlc_pkg::ST_FL_WR;
         end
         tlc_pkg::ST_FL_WR: begin
            if (can_emit) begin
               emit            = 1'b1;
               item.out_byte   = ram_rd_data;
               item.line_count = kept_ff;
               item.ws_dropped = line_ovf_ff;
               if (idx_ff + CW'(1) == count_ff) begin
                  idx_in   = '0;
                  state_in = tlc_pkg::ST_TEXT;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = tlc_pkg::ST_FL_RD;
               end
            end
         end
         tlc_pkg::ST_TEXT: begin
            if (can_emit) begin
               emit            = 1'b1;
               item.out_byte   = win_ff[0];
               item.line_count = kept_ff;
               item.ws_dropped = line_ovf_ff;
               item.run_last   = !last_ff;
               count_in        = '0;
               has_text_in     = 1'b1;
               in_text_in      = 1'b1;
               adv             = 1'b1;
            end
         end
         tlc_pkg::ST_FINISH: begin
            if (can_emit) begin
               emit            = 1'b1;
               item.stream_end = 1'b1;
               item.line_count = kept_ff;
               item.run_last   = 1'b1;
               bom_in          = '0;
               wn_in           = '0;
               last_in         = 1'b0;
               in_text_in      = 1'b0;
               comment_in      = 1'b0;
               has_text_in     = 1'b0;
               count_in        = '0;
               kept_in         = '0;
               pend_ovf_in     = 1'b0;
               line_ovf_in     = 1'b0;
               state_in        = tlc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tlc_pkg::ST_IDLE;
         end
      endcase

      // consume decided bytes from the head of the window
      if (adv) begin
         wn_left = wn_ff - {1'b0, adv_k};
         wn_in   = wn_left;
         unique case (adv_k)
            2'd1:    win_in = {8'h00, win_ff[3:1]};
            2'd2:    win_in = {16'h0000, win_ff[3:2]};
            2'd3:    win_in = {24'h000000, win_ff[3]};
            default: win_in = win_ff;
         endcase
         if (!last_ff) begin
            state_in = tlc_pkg::ST_IDLE;
         end else if (wn_left == 3'd0) begin
            state_in = tlc_pkg::ST_FINISH;
         end else begin
            state_in = tlc_pkg::ST_DECIDE;
         end
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_in       = item;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlc_pkg::ST_IDLE;
         bom_ff       <= '0;
         wn_ff        <= '0;
         last_ff      <= 1'b0;
         in_text_ff   <= 1'b0;
         comment_ff   <= 1'b0;
         has_text_ff  <= 1'b0;
         count_ff     <= '0;
         idx_ff       <= '0;
         kept_ff      <= '0;
         pend_ovf_ff  <= 1'b0;
         line_ovf_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bom_ff       <= bom_in;
         wn_ff        <= wn_in;
         last_ff      <= last_in;
         in_text_ff   <= in_text_in;
         comment_ff   <= comment_in;
         has_text_ff  <= has_text_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         kept_ff      <= kept_in;
         pend_ovf_ff  <= pend_ovf_in;
         line_ovf_ff  <= line_ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== dv/line_cleaner_checker.sv =====
`timescale 1ns / 1ps

module line_cleaner_checker
   import tlc_pkg::*;
#(
   parameter int DEPTH = tlc_pkg::PENDING_SPACE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           mismatches,
   output int           expected_left
);

   logic [1:0]  bom_pos;
   logic [7:0]  look_buf [2];
   int          look_n;
   bit          in_line;
   bit          in_comment;
   bit          line_text;
   logic [7:0]  space_buf [DEPTH];
   int          space_n;
   logic [15:0] kept;
   bit          space_lost;
   bit          line_lost;
   logic [7:0]  win [4];
   rsp_type     predicted_items [$];
   rsp_type     want;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int exp_val);
      if (got != exp_val)
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, exp_val));
   endtask

   function automatic void clear_state();
      bom_pos    = '0;
      look_n     = 0;
      in_line    = 0;
      in_comment = 0;
      line_text  = 0;
      space_n    = 0;
      kept       = '0;
      space_lost = 0;
      line_lost  = 0;
   endfunction

   function automatic void queue_item(input logic [7:0] b, input bit le, input bit se,
                                      input bit wd);
      rsp_type r;
      r.out_byte   = b;
      r.line_end   = le;
      r.stream_end = se;
      r.line_count = kept;
      r.ws_dropped = wd;
      r.run_last   = 1'b0;
      predicted_items.insert(predicted_items.size(), r);
   endfunction

   function automatic int break_len(input int p, input int n);
      if (n >= 3 && win[p] == U8_E2 && win[p+1] == U8_80 &&
          (win[p+2] == U8_A8 || win[p+2] == U8_A9))
         return 3;
      if (n >= 2 && ((win[p] == CH_CR && win[p+1] == CH_LF) ||
                     (win[p] == U8_C2 && win[p+1] == U8_85)))
         return 2;
      if (n >= 1 && (win[p] == CH_LF || win[p] == CH_VT || win[p] == CH_FF ||
                     win[p] == CH_CR))
         return 1;
      return 0;
   endfunction

   function automatic int blank_len(input int p, input int n);
      if (n >= 2 && win[p] == U8_C2 && win[p+1] == U8_A0)
         return 2;
      if (n >= 1 && (win[p] == CH_TAB || win[p] == CH_SPACE || win[p] == CH_XFF))
         return 1;
      return 0;
   endfunction

   function automatic int decide_token(input int p, input int n);
      int k;
      int j;
      k = break_len(p, n);
      if (k != 0) begin
         if (line_text) begin
            if (kept != LINE_COUNT_MAX) kept++;
            queue_item(8'h00, 1'b1, 1'b0, line_lost);
         end
         in_line    = 0;
         in_comment = 0;
         line_text  = 0;
         space_n    = 0;
         space_lost = 0;
         line_lost  = 0;
         return k;
      end
      k = blank_len(p, n);
      if (k != 0) begin
         if (in_line && !in_comment) begin
            if (space_n + k <= DEPTH) begin
               for (j = 0; j < k; j++) begin
                  space_buf[space_n] = win[p+j];
                  space_n++;
               end
            end else begin
               space_lost = 1;
            end
         end
         return k;
      end
      if (!in_comment) begin
         if (win[p] == CH_SLASH && n > 1 && win[p+1] == CH_SLASH) begin
            in_comment = 1;
            space_n    = 0;
            space_lost = 0;
         end else begin
            if (space_lost) line_lost = 1;
            for (j = 0; j < space_n; j++)
               queue_item(space_buf[j], 1'b0, 1'b0, line_lost);
            space_n    = 0;
            space_lost = 0;
            queue_item(win[p], 1'b0, 1'b0, line_lost);
            line_text = 1;
         end
         in_line = 1;
      end
      return 1;
   endfunction

   function automatic void clean_file_byte(input logic [7:0] b, input bit last);
      int n;
      int pos;
      int k;
      int i;
      int first;
      rsp_type tail;
      first = predicted_items.size();
      n = look_n;
      for (i = 0; i < n; i++) win[i] = look_buf[i];
      win[n] = b;
      n++;
      if (bom_pos < BOM_DONE) begin
         if (bom_pos == BOM_LAST_POS && n == 3 &&
             win[0] == BOM_0 && win[1] == BOM_1 && win[2] == BOM_2)
            n = 0;
         bom_pos++;
      end
      if (last) begin
         win[n] = CH_LF;
         n++;
         pos = 0;
         while (pos < n) pos += decide_token(pos, n - pos);
         queue_item(8'h00, 1'b0, 1'b1, 1'b0);
         clear_state();
      end else begin
         if (n == 3) begin
            k = decide_token(0, 3);
            for (i = 0; i < 3 - k; i++) win[i] = win[i+k];
            n -= k;
         end
         for (i = 0; i < n; i++) look_buf[i] = win[i];
         look_n = n;
      end
      if (predicted_items.size() > first) begin
         tail = predicted_items.pop_back();
         tail.run_last = 1'b1;
         predicted_items.insert(predicted_items.size(), tail);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         predicted_items.delete();
         mismatches = 0;
      end else begin
         if (req_valid && req_ready)
            clean_file_byte(req_data.in_byte, req_data.in_last);
         if (rsp_valid && rsp_ready) begin
            if (predicted_items.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               want = predicted_items.pop_front();
               check_field("out_byte", rsp_data.out_byte, want.out_byte);
               check_field("line_end", rsp_data.line_end, want.line_end);
               check_field("stream_end", rsp_data.stream_end, want.stream_end);
               check_field("line_count", rsp_data.line_count, want.line_count);
               check_field("ws_dropped", rsp_data.ws_dropped, want.ws_dropped);
               check_field("run_last", rsp_data.run_last, want.run_last);
            end
         end
      end
      expected_left <= predicted_items.size();
   end

endmodule

// ===== dv/tb_text_line_cleaner_unit.sv =====
`timescale 1ns / 1ps

module tb_text_line_cleaner_unit;
   import tlc_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int RANDOM_BYTES = 290;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int         mismatches;
   int         expected_left;
   int         cycles = 0;
   bit         calm = 1'b0;
   logic [7:0] file_bytes [$];

   text_line_cleaner_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   line_cleaner_checker cleaner_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .mismatches    (mismatches),
      .expected_left (expected_left)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_ready <= calm || ($urandom_range(0, 99) >= 12);
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!calm && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, in_last: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_file();
      int i;
      for (i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
      file_bytes.delete();
   endtask

   function automatic void append_byte(input logic [7:0] b);
      file_bytes.insert(file_bytes.size(), b);
   endfunction

   function automatic void add_newline();
      case ($urandom_range(0, 7))
         0: append_byte(CH_LF);
         1: append_byte(CH_VT);
         2: append_byte(CH_FF);
         3: append_byte(CH_CR);
         4: begin
            append_byte(CH_CR);
            append_byte(CH_LF);
         end
         5: begin
            append_byte(U8_C2);
            append_byte(U8_85);
         end
         6: begin
            append_byte(U8_E2);
            append_byte(U8_80);
            append_byte(U8_A8);
         end
         default: begin
            append_byte(U8_E2);
            append_byte(U8_80);
            append_byte(U8_A9);
         end
      endcase
   endfunction

   function automatic void add_blank();
      case ($urandom_range(0, 3))
         0: append_byte(CH_TAB);
         1: append_byte(CH_SPACE);
         2: append_byte(CH_XFF);
         default: begin
            append_byte(U8_C2);
            append_byte(U8_A0);
         end
      endcase
   endfunction

   function automatic void build_file();
      int lines;
      int ln;
      int toks;
      int t;
      int r;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(0, 255)));
         return;
      end
      if ($urandom_range(0, 4) == 0) begin
         append_byte(BOM_0);
         append_byte(BOM_1);
         append_byte(BOM_2);
      end
      lines = $urandom_range(1, 4);
      for (ln = 0; ln < lines; ln++) begin
         toks = $urandom_range(0, 8);
         for (t = 0; t < toks; t++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               if ($urandom_range(0, 9) == 0)
                  append_byte(8'($urandom_range(0, 255)));
               else
                  append_byte(8'($urandom_range(8'h21, 8'h7E)));
            end else if (r < 75) begin
               add_blank();
            end else if (r < 79) begin
               repeat ($urandom_range(28, 36)) add_blank();
            end else if (r < 86) begin
               append_byte(CH_SLASH);
               append_byte(CH_SLASH);
            end else if (r < 90) begin
               append_byte(CH_SLASH);
            end else if (r < 95) begin
               add_newline();
            end else begin
               append_byte(8'($urandom_range(0, 255)));
            end
         end
         if (ln < lines - 1 || $urandom_range(0, 1) == 1) add_newline();
      end
      if (file_bytes.size() == 0) append_byte(8'($urandom_range(0, 255)));
   endfunction

   initial begin
      int sent;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // order mark, several newline and blank kinds (no lone LF, FF, CR or space), comment, zero byte
      file_bytes = '{BOM_0, BOM_1, BOM_2, 8'h41, U8_C2, U8_A0, 8'h00, CH_CR, CH_LF,
                     CH_SLASH, CH_SLASH, 8'h7A, U8_E2, U8_80, U8_A8, CH_TAB, 8'h42,
                     CH_XFF, U8_E2, U8_80, U8_A9, U8_C2, U8_85, CH_VT};
      send_file();
      // file too short for an order mark
      file_bytes = '{BOM_0, BOM_1};
      send_file();
      file_bytes = '{CH_FF};
      send_file();

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         calm <= (sent >= 120 && sent < 200);
         build_file();
         sent += file_bytes.size();
         send_file();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_left == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== text_line_cleaner_unit.f =====
hdl/tlc_pkg.sv
hdl/tlc_ram.sv
hdl/text_line_cleaner_unit.sv
dv/line_cleaner_checker.sv
dv/tb_text_line_cleaner_unit.sv
